// ===== hdl/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int unsigned KEY_W     = 32;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned COUNT_W   = 9;

   // When TABLE_SIZE is not a power of two, the home slot is computed from the key one digit per cycle.
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned MOD_STEPS = KEY_W / DIGIT_W;
   localparam int unsigned DIGIT_CNT_W = $clog2(MOD_STEPS);

   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = COUNT_W'(192);

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_FIND   = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_PRESENT   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_VALID   = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] found_value;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // One slot of the table as it sits in the memory.
   typedef struct packed {
      mark_type           mark;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake              Payload
// req_       in         req_valid / req_ready  req_data  (kind, key, value)
// rsp_       out        rsp_valid / rsp_ready  rsp_data  (status, found_value, entry_count)
// csr_       in         csr_wr_en              csr_wr_data (max_entries)
//
// A transaction passes through READ, EXAM and DONE, probing one slot per cycle through the
// single read port of the slot memory. A TABLE_SIZE that is not a power of two adds
// the MOD state to compute the home slot, one 4-bit key digit per cycle. An insert
// refused at the entry limit, and an unused kind, go from IDLE straight to DONE.
// After reset a clearing pass marks every slot empty, one slot per cycle; req_ready
// stays low during it. A response held by a low rsp_ready keeps the block from
// finishing the next transaction, but not from starting it.

module linear_probe_hash_table #(
   parameter int unsigned TABLE_SIZE = 256
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire lpht_pkg::req_type        req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output lpht_pkg::rsp_type             rsp_data,
   input  wire                           csr_wr_en,
   input  wire [lpht_pkg::COUNT_W-1:0]   csr_wr_data
);

   localparam int unsigned IDX_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam bit          IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
   localparam logic [IDX_W:0]   MOD_N     = (IDX_W + 1)'(TABLE_SIZE);
   localparam logic [lpht_pkg::DIGIT_CNT_W-1:0] LAST_DIGIT =
      lpht_pkg::DIGIT_CNT_W'(lpht_pkg::MOD_STEPS - 1);

   // Sequencer states. CLEAR runs once after reset, MOD computes the home slot, READ
   // issues the first probe read and EXAM checks one returned slot per cycle while the
   // read of the following slot is already in flight.
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_MOD   = 6'b000100,
      S_READ  = 6'b001000,
      S_EXAM  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type                                 state_ff, state_in;
   logic [IDX_W-1:0]                          pos_ff, pos_in;
   logic [IDX_W-1:0]                          chk_pos_ff, chk_pos_in;
   logic [IDX_W-1:0]                          cnt_ff, cnt_in;
   logic                                      free_found_ff, free_found_in;
   logic [IDX_W-1:0]                          free_pos_ff, free_pos_in;
   lpht_pkg::req_type                         op_ff, op_in;
   logic [IDX_W-1:0]                          rem_ff, rem_in;
   logic [lpht_pkg::KEY_W-1:0]                kshift_ff, kshift_in;
   logic [lpht_pkg::DIGIT_CNT_W-1:0]          dig_ff, dig_in;
   logic [lpht_pkg::COUNT_W-1:0]              count_ff, count_in;
   logic [lpht_pkg::COUNT_W-1:0]              max_entries_ff;
   lpht_pkg::rsp_type                         res_ff, res_in;
   logic                                      rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_type                         rsp_data_ff, rsp_data_in;

   // Slot memory: mark, key and value of each slot in one word.
   lpht_pkg::entry_type                       slot_mem [TABLE_SIZE];
   lpht_pkg::entry_type                       rd_data_ff;
   logic                                      wr_en;
   logic [IDX_W-1:0]                          wr_addr;
   lpht_pkg::entry_type                       wr_data;

   // Probe decode of the slot returned by the memory.
   logic                                      slot_valid;
   logic                                      slot_hit;
   logic                                      slot_empty;
   logic                                      walk_end;
   logic                                      free_any;
   logic [IDX_W-1:0]                          free_slot;
   logic [IDX_W-1:0]                          pos_next;
   logic [IDX_W-1:0]                          rem_next;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pos_next = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   // The read address is always the next slot of the walk; reads that are not needed
   // are simply discarded.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[pos_ff];
   end

   // Remainder of the key by TABLE_SIZE, one digit per cycle by restoring steps.
   always_comb begin
      logic [IDX_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < lpht_pkg::DIGIT_W; i++) begin
         r = {r[IDX_W-1:0], kshift_ff[lpht_pkg::KEY_W-1-i]};
         if (r >= MOD_N) begin
            r = r - MOD_N;
         end
      end
      rem_next = r[IDX_W-1:0];
   end

   assign slot_valid = (rd_data_ff.mark == lpht_pkg::MARK_VALID);
   assign slot_hit   = slot_valid && (rd_data_ff.key == op_ff.key);
   assign slot_empty = (rd_data_ff.mark == lpht_pkg::MARK_EMPTY);
   assign walk_end   = slot_hit || slot_empty || (cnt_ff == LAST_SLOT);
   assign free_any   = free_found_ff || !slot_valid;
   assign free_slot  = free_found_ff ? free_pos_ff : chk_pos_ff;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      chk_pos_in    = chk_pos_ff;
      cnt_in        = cnt_ff;
      free_found_in = free_found_ff;
      free_pos_in   = free_pos_ff;
      op_in         = op_ff;
      rem_in        = rem_ff;
      kshift_in     = kshift_ff;
      dig_in        = dig_ff;
      count_in      = count_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_pos_ff;
      wr_data       = rd_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff;
            wr_data.mark = lpht_pkg::MARK_EMPTY;
            wr_data.key  = '0;
            wr_data.value = '0;
            pos_in       = pos_next;
            if (pos_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in              = req_data;
               free_found_in      = 1'b0;
               res_in.found_value = '0;
               res_in.entry_count = count_ff;
               if (req_data.kind == lpht_pkg::KIND_INSERT && count_ff >= max_entries_ff) begin
                  res_in.status = lpht_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else if (req_data.kind != lpht_pkg::KIND_INSERT &&
                            req_data.kind != lpht_pkg::KIND_FIND &&
                            req_data.kind != lpht_pkg::KIND_REMOVE) begin
                  res_in.status = lpht_pkg::ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else if (IS_POW2) begin
                  pos_in   = req_data.key[IDX_W-1:0];
                  state_in = S_READ;
               end else begin
                  rem_in    = '0;
                  kshift_in = req_data.key;
                  dig_in    = '0;
                  state_in  = S_MOD;
               end
            end
         end

         S_MOD: begin
            rem_in    = rem_next;
            kshift_in = kshift_ff << lpht_pkg::DIGIT_W;
            dig_in    = dig_ff + 1'b1;
            if (dig_ff == LAST_DIGIT) begin
               pos_in   = rem_next;
               state_in = S_READ;
            end
         end

         S_READ: begin
            chk_pos_in = pos_ff;
            pos_in     = pos_next;
            cnt_in     = '0;
            state_in   = S_EXAM;
         end

         S_EXAM: begin
            chk_pos_in = pos_ff;
            pos_in     = pos_next;
            cnt_in     = cnt_ff + 1'b1;
            if (!slot_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_pos_in   = chk_pos_ff;
            end
            if (walk_end) begin
               state_in           = S_DONE;
               res_in.found_value = '0;
               res_in.status      = lpht_pkg::ST_NOT_FOUND;
               res_in.entry_count = count_ff;
               case (op_ff.kind)
                  lpht_pkg::KIND_INSERT: begin
                     if (slot_hit) begin
                        res_in.status = lpht_pkg::ST_PRESENT;
                     end else if (free_any) begin
                        wr_en              = 1'b1;
                        wr_addr            = free_slot;
                        wr_data.mark       = lpht_pkg::MARK_VALID;
                        wr_data.key        = op_ff.key;
                        wr_data.value      = op_ff.value;
                        count_in           = count_ff + 1'b1;
                        res_in.status      = lpht_pkg::ST_OK;
                        res_in.entry_count = count_ff + 1'b1;
                     end else begin
                        res_in.status = lpht_pkg::ST_FULL;
                     end
                  end
                  lpht_pkg::KIND_FIND: begin
                     if (slot_hit) begin
                        res_in.status      = lpht_pkg::ST_OK;
                        res_in.found_value = rd_data_ff.value;
                     end
                  end
                  lpht_pkg::KIND_REMOVE: begin
                     if (slot_hit) begin
                        wr_en         = 1'b1;
                        wr_addr       = chk_pos_ff;
                        wr_data.mark  = lpht_pkg::MARK_DELETED;
                        res_in.status = lpht_pkg::ST_OK;
                        if (count_ff != '0) begin
                           count_in           = count_ff - 1'b1;
                           res_in.entry_count = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     res_in.status = lpht_pkg::ST_NOT_FOUND;
                  end
               endcase
            end
         end

         S_DONE: begin
            // The result moves into the output register as soon as it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         pos_ff         <= '0;
         cnt_ff         <= '0;
         dig_ff         <= '0;
         free_found_ff  <= 1'b0;
         count_ff       <= '0;
         max_entries_ff <= lpht_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         dig_ff        <= dig_in;
         free_found_ff <= free_found_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            max_entries_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      chk_pos_ff  <= chk_pos_in;
      free_pos_ff <= free_pos_in;
      op_ff       <= op_in;
      rem_ff      <= rem_in;
      kshift_ff   <= kshift_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/lpht_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire lpht_pkg::req_type       req_data,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire lpht_pkg::rsp_type       rsp_data,
   input wire                          csr_wr_en,
   input wire [lpht_pkg::COUNT_W-1:0]  csr_wr_data
);

   // A stalled response stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A value is only returned with a successful status.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lpht_pkg::ST_OK |-> rsp_data.found_value == '0)
      else $error("found_value nonzero on a failed transaction");

   // One transaction at a time: an accepted request closes the input for the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // The count moves by at most one between two responses on a taken result.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid |->
         rsp_data.entry_count == $past(rsp_data.entry_count) ||
         rsp_data.entry_count == $past(rsp_data.entry_count) + 1'b1 ||
         rsp_data.entry_count == $past(rsp_data.entry_count) - 1'b1)
      else $error("entry count jumped between consecutive responses");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
